### hw/rtl/gftm_pkg.sv
// Package for the grid frequency trip monitor: shared widths, register
// indexes and the structs passed between the register file, core and top.
// No dependencies.
package gftm_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int LIMIT_WIDTH  = 16;
   localparam int COUNT_WIDTH  = 16;
   localparam int TIME_WIDTH   = 16;
   localparam int CSR_WIDTH    = 32;
   localparam int INDEX_WIDTH  = 3;
   localparam int RSP_WIDTH    = 8;
   // Compares are done at a width that holds both a sample and a limit.
   localparam int CMP_WIDTH    = (SAMPLE_WIDTH > LIMIT_WIDTH) ? SAMPLE_WIDTH : LIMIT_WIDTH;

   typedef logic [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic [LIMIT_WIDTH-1:0]  limit_type;
   typedef logic [COUNT_WIDTH-1:0]  count_type;
   typedef logic [TIME_WIDTH-1:0]   ticks_type;
   typedef logic [CMP_WIDTH-1:0]    cmp_type;

   typedef enum logic [INDEX_WIDTH-1:0] {
      REG_OVER_LIMITS     = 3'd0,
      REG_UNDER_LIMITS    = 3'd1,
      REG_RECOVERY_WINDOW = 3'd2,
      REG_OVER1_TRIP      = 3'd3,
      REG_OVER2_TRIP      = 3'd4,
      REG_UNDER1_TRIP     = 3'd5,
      REG_UNDER2_TRIP     = 3'd6,
      REG_RECOVERY_TIME   = 3'd7
   } reg_index_type;

   typedef struct packed {
      limit_type over1_limit;
      limit_type over2_limit;
      limit_type under1_limit;
      limit_type under2_limit;
      limit_type window_low;
      limit_type window_high;
      ticks_type over1_trip_time;
      ticks_type over2_trip_time;
      ticks_type under1_trip_time;
      ticks_type under2_trip_time;
      ticks_type recovery_time;
   } cfg_type;

   typedef struct packed {
      count_type under1_count;
      count_type under2_count;
      count_type over1_count;
      count_type over2_count;
      count_type recovery_count;
   } count_set_type;

endpackage

### hw/rtl/grid_frequency_trip_monitor.sv
// Top level of the grid frequency trip monitor: input register, decision
// core, result register and configuration register file.
// Depends on gftm_pkg, gftm_csr and gftm_core.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_tvalid/tready     tdata: frequency; tuser: fault_active
//   rsp      out        rsp_tvalid/tready     tdata: fault (bit 0)
//   csr      in         csr_valid/csr_ready   csr_index, csr_data
//
// Each sample word is captured in an input register, judged by the core and
// written to the result register, from which its result word is presented;
// one word is accepted per cycle while the result side does not stall.
// Reset is synchronous and clears all valid flags, tick counters and
// configuration registers (over limits to all ones, everything else to zero).
// A stall on the result side holds the result register; the input register
// still takes one more word, then req_tready drops until the result leaves.
// Configuration writes are always accepted.
module grid_frequency_trip_monitor (
   input  logic                               clock,
   input  logic                               reset,
   // Sample channel.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [gftm_pkg::SAMPLE_WIDTH-1:0]  req_tdata,  // [15:0] frequency
   input  logic                               req_tuser,  // [0] fault_active
   // Result channel.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [gftm_pkg::RSP_WIDTH-1:0]     rsp_tdata,  // [0] fault, rest zero
   // Configuration write channel.
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [gftm_pkg::INDEX_WIDTH-1:0]   csr_index,
   input  logic [gftm_pkg::CSR_WIDTH-1:0]     csr_data
);
   import gftm_pkg::*;

   cfg_type       cfg;
   count_set_type counts;

   // Input register holding one accepted sample word.
   logic       in_valid_ff;
   sample_type in_freq_ff;
   logic       in_latched_ff;

   // Result register.
   logic       out_valid_ff;
   logic       out_fault_ff;

   logic       out_free;
   logic       step;
   logic       fault;

   // The result register can take a new word when it is empty or its word
   // is leaving in this cycle; a held word in the input register then moves.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_WIDTH-1){1'b0}}, out_fault_ff};

   gftm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   gftm_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .frequency    (in_freq_ff),
      .fault_active (in_latched_ff),
      .cfg          (cfg),
      .fault        (fault),
      .counts       (counts)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_freq_ff    <= req_tdata;
         in_latched_ff <= req_tuser;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_fault_ff <= fault;
      end
   end

   // Each judged word reaches the result register in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_tvalid)
      else $error("judged sample word did not reach the result register");

   // A full input stage behind a stalled result must hold off new words.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("sample word accepted while both stages are held");

   // Under and over counters are never running at the same time.
   assert property (@(posedge clock) disable iff (reset)
      !(((counts.under1_count != '0) || (counts.under2_count != '0)) &&
        ((counts.over1_count != '0) || (counts.over2_count != '0))))
      else $error("under and over tick counters both nonzero");

   // Counters only move when a word is judged.
   assert property (@(posedge clock) disable iff (reset)
      !$past(step) && !$past(reset) |-> $stable(counts))
      else $error("tick counters changed with no sample word judged");

endmodule

### hw/rtl/gftm_csr.sv
// Configuration register file of the grid frequency trip monitor.
// Depends on gftm_pkg.
module gftm_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [gftm_pkg::INDEX_WIDTH-1:0] csr_index,
   input  logic [gftm_pkg::CSR_WIDTH-1:0]   csr_data,
   output gftm_pkg::cfg_type             cfg
);
   import gftm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_OVER_LIMITS: begin
               cfg_in.over1_limit = csr_data[LIMIT_WIDTH-1:0];
               cfg_in.over2_limit = csr_data[2*LIMIT_WIDTH-1:LIMIT_WIDTH];
            end
            REG_UNDER_LIMITS: begin
               cfg_in.under1_limit = csr_data[LIMIT_WIDTH-1:0];
               cfg_in.under2_limit = csr_data[2*LIMIT_WIDTH-1:LIMIT_WIDTH];
            end
            REG_RECOVERY_WINDOW: begin
               cfg_in.window_low  = csr_data[LIMIT_WIDTH-1:0];
               cfg_in.window_high = csr_data[2*LIMIT_WIDTH-1:LIMIT_WIDTH];
            end
            REG_OVER1_TRIP:    cfg_in.over1_trip_time  = csr_data[TIME_WIDTH-1:0];
            REG_OVER2_TRIP:    cfg_in.over2_trip_time  = csr_data[TIME_WIDTH-1:0];
            REG_UNDER1_TRIP:   cfg_in.under1_trip_time = csr_data[TIME_WIDTH-1:0];
            REG_UNDER2_TRIP:   cfg_in.under2_trip_time = csr_data[TIME_WIDTH-1:0];
            REG_RECOVERY_TIME: cfg_in.recovery_time    = csr_data[TIME_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{over1_limit: '1, over2_limit: '1, default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### hw/rtl/gftm_core.sv
// Decision logic and tick counters of the grid frequency trip monitor.
// Depends on gftm_pkg.
module gftm_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  gftm_pkg::sample_type  frequency,
   input  logic                  fault_active,
   input  gftm_pkg::cfg_type     cfg,
   output logic                  fault,
   output gftm_pkg::count_set_type counts
);
   import gftm_pkg::*;

   count_set_type cnt_ff;
   count_set_type cnt_in;
   count_set_type bumped;
   cmp_type       f;

   assign counts = cnt_ff;
   assign f      = cmp_type'(frequency);

   always_comb begin
      bumped.under1_count   = cnt_ff.under1_count + 1'b1;
      bumped.under2_count   = cnt_ff.under2_count + 1'b1;
      bumped.over1_count    = cnt_ff.over1_count + 1'b1;
      bumped.over2_count    = cnt_ff.over2_count + 1'b1;
      bumped.recovery_count = cnt_ff.recovery_count + 1'b1;
   end

   always_comb begin
      cnt_in = cnt_ff;
      fault  = 1'b0;
      if (!fault_active) begin
         if (f < cmp_type'(cfg.under2_limit)) begin
            cnt_in.under1_count = bumped.under1_count;
            cnt_in.under2_count = bumped.under2_count;
            cnt_in.over1_count  = '0;
            cnt_in.over2_count  = '0;
            if (bumped.under2_count >= cfg.under2_trip_time) begin
               cnt_in.under1_count = '0;
               cnt_in.under2_count = '0;
               fault               = 1'b1;
            end
         end else if (f < cmp_type'(cfg.under1_limit)) begin
            cnt_in.under1_count = bumped.under1_count;
            cnt_in.under2_count = '0;
            cnt_in.over1_count  = '0;
            cnt_in.over2_count  = '0;
            if (bumped.under1_count >= cfg.under1_trip_time) begin
               cnt_in.under1_count = '0;
               fault               = 1'b1;
            end
         end else if (f > cmp_type'(cfg.over2_limit)) begin
            cnt_in.under1_count = '0;
            cnt_in.under2_count = '0;
            cnt_in.over1_count  = bumped.over1_count;
            cnt_in.over2_count  = bumped.over2_count;
            if (bumped.over2_count >= cfg.over2_trip_time) begin
               cnt_in.over1_count = '0;
               cnt_in.over2_count = '0;
               fault              = 1'b1;
            end
         end else if (f > cmp_type'(cfg.over1_limit)) begin
            cnt_in.under1_count = '0;
            cnt_in.under2_count = '0;
            cnt_in.over1_count  = bumped.over1_count;
            cnt_in.over2_count  = '0;
            if (bumped.over1_count >= cfg.over1_trip_time) begin
               cnt_in.over1_count = '0;
               fault              = 1'b1;
            end
         end else begin
            cnt_in.under1_count = '0;
            cnt_in.under2_count = '0;
            cnt_in.over1_count  = '0;
            cnt_in.over2_count  = '0;
         end
      end else begin
         fault = 1'b1;
         if ((f > cmp_type'(cfg.window_low)) && (f < cmp_type'(cfg.window_high))) begin
            cnt_in.recovery_count = bumped.recovery_count;
            if (bumped.recovery_count >= cfg.recovery_time) begin
               cnt_in.recovery_count = '0;
               fault                 = 1'b0;
            end
         end else begin
            cnt_in.recovery_count = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (step) begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

### dv/grid_frequency_trip_monitor_tb.sv
`timescale 1ns / 100ps

// Self-checking stream testbench for the grid frequency trip monitor. It
// predicts every fault word from its own model of the trip counters.
// Depends on gftm_pkg and the grid_frequency_trip_monitor RTL.
module grid_frequency_trip_monitor_tb;
   import gftm_pkg::*;

   // The watchdog counts cycles with no handshake on any channel. The slowest
   // correct stretch is a sender gap plus a receiver stall, or the settle time
   // between phases, all far below this limit.
   localparam int WATCHDOG_LIMIT = 2000;
   // Settle time after the last word of a phase is checked, with margin.
   localparam int SETTLE_CYCLES  = 8;
   localparam int RANDOM_PHASES  = 11;
   localparam int PHASE_WORDS    = 150;
   localparam int ERROR_PRINTS   = 50;

   // One sample word as the testbench queues it: the frequency goes out on
   // tdata and the latched-fault flag on tuser.
   typedef struct packed {
      sample_type freq;
      logic       latched;
   } sample_word_type;

   typedef enum int {PROF_NOMINAL, PROF_FLOOR, PROF_CEILING, PROF_WILD} profile_type;
   typedef enum int {
      BAND_UNDER2, BAND_UNDER1, BAND_NORMAL, BAND_OVER1, BAND_OVER2, BAND_WINDOW
   } band_type;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [SAMPLE_WIDTH-1:0] req_tdata  = '0;    // [15:0] frequency
   logic                    req_tuser  = 1'b0;  // [0] fault_active
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_WIDTH-1:0]    rsp_tdata;          // [0] fault, [7:1] zero
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   reg_index_type           csr_index  = REG_OVER_LIMITS;
   logic [CSR_WIDTH-1:0]    csr_data   = '0;

   grid_frequency_trip_monitor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------------
   // Trip model. The thresholds and times mirror the block's registers and
   // start from their reset values; the tick counters mirror its state.
   // ------------------------------------------------------------------------
   limit_type over1_lim  = '1;
   limit_type over2_lim  = '1;
   limit_type under1_lim = '0;
   limit_type under2_lim = '0;
   limit_type win_low    = '0;
   limit_type win_high   = '0;
   ticks_type over1_trip   = '0;
   ticks_type over2_trip   = '0;
   ticks_type under1_trip  = '0;
   ticks_type under2_trip  = '0;
   ticks_type recover_after = '0;

   count_type under1_ticks = '0;
   count_type under2_ticks = '0;
   count_type over1_ticks  = '0;
   count_type over2_ticks  = '0;
   count_type recov_ticks  = '0;

   // Register writes land in the model at the edge where the block takes them.
   function automatic void apply_setting(reg_index_type idx, logic [CSR_WIDTH-1:0] value);
      case (idx)
         REG_OVER_LIMITS:     {over2_lim, over1_lim}   = value;
         REG_UNDER_LIMITS:    {under2_lim, under1_lim} = value;
         REG_RECOVERY_WINDOW: {win_high, win_low}      = value;
         REG_OVER1_TRIP:      over1_trip    = value[TIME_WIDTH-1:0];
         REG_OVER2_TRIP:      over2_trip    = value[TIME_WIDTH-1:0];
         REG_UNDER1_TRIP:     under1_trip   = value[TIME_WIDTH-1:0];
         REG_UNDER2_TRIP:     under2_trip   = value[TIME_WIDTH-1:0];
         REG_RECOVERY_TIME:   recover_after = value[TIME_WIDTH-1:0];
         default: ;
      endcase
   endfunction

   // Judges one sample and advances the tick counters. The bands are tried in
   // priority order: deep under, under, deep over, over. A deep band also
   // counts on its shallow counter, so a shallow counter can wrap at 2^16
   // while the deep one is still short of its trip time.
   function automatic logic judge_sample(sample_type f, logic latched);
      logic tripped;
      tripped = 1'b0;
      if (latched) begin
         // A latched fault holds unless the sample stays strictly inside the
         // recovery window for long enough; the level counters are frozen.
         tripped = 1'b1;
         if (f > win_low && f < win_high) begin
            recov_ticks += 1'b1;
            if (recov_ticks >= recover_after) begin
               recov_ticks = '0;
               tripped     = 1'b0;
            end
         end else begin
            recov_ticks = '0;
         end
      end else if (f < under2_lim) begin
         under1_ticks += 1'b1;
         under2_ticks += 1'b1;
         over1_ticks  = '0;
         over2_ticks  = '0;
         if (under2_ticks >= under2_trip) begin
            under1_ticks = '0;
            under2_ticks = '0;
            tripped      = 1'b1;
         end
      end else if (f < under1_lim) begin
         under1_ticks += 1'b1;
         under2_ticks = '0;
         over1_ticks  = '0;
         over2_ticks  = '0;
         if (under1_ticks >= under1_trip) begin
            under1_ticks = '0;
            tripped      = 1'b1;
         end
      end else if (f > over2_lim) begin
         under1_ticks = '0;
         under2_ticks = '0;
         over1_ticks  += 1'b1;
         over2_ticks  += 1'b1;
         if (over2_ticks >= over2_trip) begin
            over1_ticks = '0;
            over2_ticks = '0;
            tripped     = 1'b1;
         end
      end else if (f > over1_lim) begin
         under1_ticks = '0;
         under2_ticks = '0;
         over1_ticks  += 1'b1;
         over2_ticks  = '0;
         if (over1_ticks >= over1_trip) begin
            over1_ticks = '0;
            tripped     = 1'b1;
         end
      end else begin
         // In band: every level counter starts over.
         under1_ticks = '0;
         under2_ticks = '0;
         over1_ticks  = '0;
         over2_ticks  = '0;
      end
      return tripped;
   endfunction

   // ------------------------------------------------------------------------
   // Shared bookkeeping between the stimulus, driver and monitor.
   // ------------------------------------------------------------------------
   sample_word_type pending_words[$];
   logic         fault_expected[$];
   int unsigned  words_queued  = 0;
   int unsigned  words_checked = 0;
   int unsigned  fail_count    = 0;
   int unsigned  faults_seen   = 0;
   int unsigned  clears_seen   = 0;
   int unsigned  phases_run    = 0;
   // While set, the sender never pauses and the receiver never stalls.
   logic         steady        = 1'b0;

   // ------------------------------------------------------------------------
   // Sample driver. A word stays on the bus until it is taken; the sender
   // works in bursts of random length separated by random gaps, and some
   // bursts follow each other with no gap at all.
   // ------------------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin : sample_driver
      sample_word_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else begin
         // The prediction is made at the edge that hands the word to the block.
         if (req_tvalid && req_tready) begin
            fault_expected.push_back(judge_sample(req_tdata, req_tuser));
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0 && !steady) begin
               req_tvalid <= 1'b0;
               gap_left   <= gap_left - 1;
            end else if (pending_words.size() != 0) begin
               w = pending_words.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= w.freq;
               req_tuser  <= w.latched;
               if (burst_left > 1) begin
                  burst_left <= burst_left - 1;
               end else begin
                  burst_left <= $urandom_range(1, 40);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Fault monitor. Each result word is checked against the oldest
   // prediction. The receiver switches between regimes of its own: always
   // ready, coin-flip ready, and two repeating patterns of ready and stall,
   // one of them with long stalls.
   // ------------------------------------------------------------------------
   int          regime       = 0;
   int          regime_left  = 0;
   int unsigned pattern_tick = 0;

   always @(posedge clock) begin : fault_monitor
      logic want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (fault_expected.size() == 0) begin
            if (fail_count < ERROR_PRINTS)
               $error("fault word with no sample outstanding: tdata %0h", rsp_tdata);
            fail_count++;
         end else begin
            want = fault_expected.pop_front();
            words_checked++;
            if (rsp_tdata[0] !== want) begin
               if (fail_count < ERROR_PRINTS)
                  $error("field fault: expected %0b, actual %0b", want, rsp_tdata[0]);
               fail_count++;
            end
            if (rsp_tdata[RSP_WIDTH-1:1] !== '0) begin
               if (fail_count < ERROR_PRINTS)
                  $error("field padding: expected 0, actual %0h", rsp_tdata[RSP_WIDTH-1:1]);
               fail_count++;
            end
            if (want)
               faults_seen++;
            else
               clears_seen++;
         end
      end

      pattern_tick <= pattern_tick + 1;
      if (regime_left == 0) begin
         regime      <= $urandom_range(0, 3);
         regime_left <= $urandom_range(32, 256);
      end else begin
         regime_left <= regime_left - 1;
      end
      if (steady) begin
         rsp_tready <= 1'b1;
      end else begin
         case (regime)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            2:       rsp_tready <= (pattern_tick % 5) < 2;
            default: rsp_tready <= (pattern_tick % 16) >= 6;
         endcase
      end
   end

   // Watchdog: a hung handshake on any channel ends the run.
   int quiet_cycles = 0;

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: %0d cycles without a handshake, %0d words outstanding.",
                  quiet_cycles, words_queued - words_checked);
         $display("** grid_frequency_trip_monitor: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------------
   function automatic void queue_word(sample_type freq, logic latched);
      sample_word_type w;
      w.freq    = freq;
      w.latched = latched;
      pending_words.push_back(w);
      words_queued++;
   endfunction

   // Called just after a rising edge; keeps csr_valid high across back to
   // back writes, and the caller lowers it after the last one.
   task automatic write_reg(reg_index_type idx, logic [CSR_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      apply_setting(idx, value);
   endtask

   // A time register only keeps its low half, so the upper half sometimes
   // carries junk that the block has to drop.
   function automatic logic [CSR_WIDTH-1:0] ticks_word(ticks_type t);
      return {(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0000), t};
   endfunction

   task automatic program_all(logic [CSR_WIDTH-1:0] over_l, logic [CSR_WIDTH-1:0] under_l,
                              logic [CSR_WIDTH-1:0] window, ticks_type t_over1,
                              ticks_type t_over2, ticks_type t_under1,
                              ticks_type t_under2, ticks_type t_recover);
      write_reg(REG_OVER_LIMITS, over_l);
      write_reg(REG_UNDER_LIMITS, under_l);
      write_reg(REG_RECOVERY_WINDOW, window);
      write_reg(REG_OVER1_TRIP, ticks_word(t_over1));
      write_reg(REG_OVER2_TRIP, ticks_word(t_over2));
      write_reg(REG_UNDER1_TRIP, ticks_word(t_under1));
      write_reg(REG_UNDER2_TRIP, ticks_word(t_under2));
      write_reg(REG_RECOVERY_TIME, ticks_word(t_recover));
      csr_valid <= 1'b0;
      phases_run++;
   endtask

   // Returns once every queued word has come back checked and the block has
   // had time to settle, always just after a rising edge.
   task automatic wait_drained();
      while (words_checked != words_queued) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Picks a sample inside a band of the current setting. A fifth of the
   // picks sit exactly on a band edge; an empty band falls back to noise.
   function automatic sample_type sample_in(band_type band);
      int lo;
      int hi;
      case (band)
         BAND_UNDER2: begin lo = 0;                   hi = int'(under2_lim) - 1; end
         BAND_UNDER1: begin lo = int'(under2_lim);    hi = int'(under1_lim) - 1; end
         BAND_NORMAL: begin lo = int'(under1_lim);    hi = int'(over1_lim);      end
         BAND_OVER1:  begin lo = int'(over1_lim) + 1; hi = int'(over2_lim);      end
         BAND_OVER2:  begin lo = int'(over2_lim) + 1; hi = 'hFFFF;               end
         default:     begin lo = int'(win_low) + 1;   hi = int'(win_high) - 1;   end
      endcase
      if (hi < lo)
         return sample_type'($urandom);
      if ($urandom_range(0, 4) == 0)
         return sample_type'(($urandom_range(0, 1) != 0) ? lo : hi);
      return sample_type'($urandom_range(hi, lo));
   endfunction

   // Runs of samples that stay in one band, so that counters climb to their
   // trip times, mixed with latched runs aimed at the recovery window. About
   // one word in ten is noise with a random flag.
   task automatic queue_runs(int words);
      int       left;
      int       run;
      band_type band;
      logic     latched;
      left = words;
      while (left > 0) begin
         latched = ($urandom_range(0, 3) == 0);
         band    = latched ? BAND_WINDOW : band_type'($urandom_range(0, 4));
         run     = $urandom_range(1, 14);
         if (run > left)
            run = left;
         repeat (run) begin
            if ($urandom_range(0, 9) == 0)
               queue_word(sample_type'($urandom), 1'($urandom));
            else
               queue_word(sample_in(band), latched);
         end
         left -= run;
      end
   endtask

   function automatic ticks_type short_ticks();
      return ($urandom_range(0, 3) == 0) ? ticks_type'(0) : ticks_type'($urandom_range(1, 9));
   endfunction

   task automatic random_phase(profile_type prof);
      limit_type centre;
      limit_type d1;
      limit_type d2;
      limit_type e1;
      limit_type e2;
      case (prof)
         PROF_FLOOR: begin
            // Every nonzero sample is deep over and trips at once; the
            // recovery window is empty.
            program_all('0, '0, '0, '0, '0, '0, '0, '0);
         end
         PROF_CEILING: begin
            // Almost every sample is deep under, no counter reaches its
            // trip time, and the window spans all but the two end values.
            program_all('1, '1, {16'hFFFF, 16'h0000}, '1, '1, '1, '1, '1);
         end
         PROF_WILD: begin
            // Unordered thresholds: bands overlap or vanish.
            program_all($urandom, $urandom, $urandom,
                        ticks_type'($urandom_range(0, 12)), ticks_type'($urandom_range(0, 12)),
                        ticks_type'($urandom_range(0, 12)), ticks_type'($urandom_range(0, 12)),
                        ticks_type'($urandom_range(0, 12)));
         end
         default: begin
            centre = limit_type'($urandom_range(16'h0400, 16'hFB00));
            d1     = limit_type'($urandom_range(2, 120));
            d2     = d1 + limit_type'($urandom_range(1, 200));
            e1     = limit_type'($urandom_range(2, 120));
            e2     = e1 + limit_type'($urandom_range(1, 200));
            program_all({centre + e2, centre + e1}, {centre - d2, centre - d1},
                        {centre + limit_type'($urandom_range(1, e1 + 2)),
                         centre - limit_type'($urandom_range(1, d1 + 2))},
                        short_ticks(), short_ticks(), short_ticks(), short_ticks(),
                        short_ticks());
         end
      endcase
      queue_runs(PHASE_WORDS);
      wait_drained();
   endtask

   // ------------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------------
   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset setting: nothing is ever out of band, and the recovery window
      // is empty so a latched fault always holds.
      phases_run++;
      queue_word(16'h0000, 1'b0);
      queue_word(16'hFFFF, 1'b0);
      queue_word(16'h8000, 1'b1);
      queue_word(16'h7FFF, 1'b1);
      wait_drained();

      // Directed setting: under 800/900, over 1100/1200, window 950..1050.
      // These words go through back to back with the receiver always ready.
      program_all({16'd1200, 16'd1100}, {16'd800, 16'd900}, {16'd1050, 16'd950},
                  16'd2, 16'd1, 16'd2, 16'd1, 16'd2);
      steady = 1'b1;
      queue_word(16'd1000, 1'b0);   // in band
      queue_word(16'd0, 1'b0);      // deep under, trips on the first tick
      queue_word(16'd850, 1'b0);    // under, first tick
      queue_word(16'd850, 1'b0);    // under, trips on the second tick
      queue_word(16'd1150, 1'b0);   // over, first tick
      queue_word(16'd1150, 1'b0);   // over, trips
      queue_word(16'hFFFF, 1'b0);   // deep over, trips at once
      queue_word(16'd1100, 1'b0);   // on the over threshold: still in band
      queue_word(16'd900, 1'b0);    // on the under threshold: still in band
      queue_word(16'd800, 1'b0);    // on the deep threshold: shallow under band
      queue_word(16'd1150, 1'b0);   // over clears the under count
      queue_word(16'd850, 1'b0);    // so under starts from one again
      queue_word(16'd1000, 1'b1);   // latched, inside the window
      queue_word(16'd1000, 1'b1);   // recovers on the second tick
      queue_word(16'd950, 1'b1);    // window bounds are exclusive
      queue_word(16'd1050, 1'b1);
      queue_word(16'd1001, 1'b1);
      queue_word(16'd0, 1'b1);      // leaving the window restarts the count
      queue_word(16'd1049, 1'b1);
      queue_word(16'd951, 1'b1);    // recovers
      wait_drained();
      steady = 1'b0;

      random_phase(PROF_NOMINAL);
      random_phase(PROF_FLOOR);
      random_phase(PROF_CEILING);
      for (int p = 3; p < RANDOM_PHASES; p++) begin
         case ($urandom_range(0, 9))
            0:       random_phase(PROF_FLOOR);
            1:       random_phase(PROF_CEILING);
            2, 3:    random_phase(PROF_WILD);
            default: random_phase(PROF_NOMINAL);
         endcase
      end

      $display("Checked %0d fault words across %0d settings: %0d faulted, %0d healthy.",
               words_checked, phases_run, faults_seen, clears_seen);
      $display("Covered both trip levels per side, recovery, zero and full-scale times, "
               , "back-to-back words.");
      if (fail_count == 0 && fault_expected.size() == 0) begin
         $display("** grid_frequency_trip_monitor: PASSED **");
      end else begin
         $display("** grid_frequency_trip_monitor: FAILED **");
      end
      $finish;
   end

endmodule
